// ----- hdl/rdat_pkg.sv -----
package rdat_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int ACK_QUEUE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS = 16;
  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

  localparam logic [2:0] MODE_SEND  = 3'd0;
  localparam logic [2:0] MODE_DATA  = 3'd1;
  localparam logic [2:0] MODE_ACK   = 3'd2;
  localparam logic [2:0] MODE_TICK  = 3'd3;
  localparam logic [2:0] MODE_DRAIN = 3'd4;
  localparam logic [2:0] MODE_CLEAR = 3'd5;

  localparam logic [2:0] KIND_ASSIGNED  = 3'd0;
  localparam logic [2:0] KIND_DATA_OK   = 3'd1;
  localparam logic [2:0] KIND_DATA_REJ  = 3'd2;
  localparam logic [2:0] KIND_SUCCESS   = 3'd3;
  localparam logic [2:0] KIND_UNMATCHED = 3'd4;
  localparam logic [2:0] KIND_TIMEOUT   = 3'd5;
  localparam logic [2:0] KIND_ACK_OUT   = 3'd6;
  localparam logic [2:0] KIND_FULL      = 3'd7;

  typedef struct packed {
    logic start;
    logic scan_step;
    logic emit;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic hit;
    logic out_busy;
  } ctl_sts_t;

endpackage

// ----- hdl/rdat_ctrl.sv -----
module rdat_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rdat_pkg::ctl_sts_t  sts,
  output rdat_pkg::ctl_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          if (!sts.out_busy) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
        end else if (sts.hit) begin
          state_next = S_EMIT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          cmd.scan_step = 1'b1;
          state_next = S_SCAN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/rdat_dpath.sv -----
module rdat_dpath #(
  parameter int TABLE_DEPTH = rdat_pkg::TABLE_DEPTH_DEF,
  parameter int ACK_QUEUE_DEPTH = rdat_pkg::ACK_QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  rdat_pkg::ctl_cmd_t cmd,
  output rdat_pkg::ctl_sts_t sts,
  input  logic               cfg_valid,
  input  logic [31:0]        cfg_data,
  input  logic [2:0]         mode,
  input  logic [31:0]        seq_number,
  input  logic               wants_notify,
  input  logic               last_in_list,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         kind,
  output logic [31:0]        seq_out,
  output logic               notify,
  output logic               acks_waiting,
  output logic [4:0]         ack_total,
  output logic               end_of_list,
  output logic               last
);

  localparam int TW = $clog2(TABLE_DEPTH);
  localparam int QW = $clog2(ACK_QUEUE_DEPTH);
  localparam int CW = $clog2(ACK_QUEUE_DEPTH + 1);
  localparam int IW0 = (TW > CW) ? TW : CW;
  localparam int IW = (IW0 > 5) ? IW0 + 1 : 6;

  logic [31:0] timeout_ticks, next_out_seq, expected_in_seq, current_time;
  logic [TABLE_DEPTH-1:0] pvalid;
  logic [31:0] pseq [TABLE_DEPTH];
  logic [31:0] ptime [TABLE_DEPTH];
  logic        pnot [TABLE_DEPTH];
  logic [31:0] aq [ACK_QUEUE_DEPTH];
  logic [QW-1:0] head;
  logic [CW-1:0] count;

  logic [2:0]  r_mode;
  logic [31:0] r_seq;
  logic        r_wn, r_lil, r_found;
  logic [IW-1:0] idx;
  logic [4:0]  nres, take;

  logic [TW-1:0] ti;
  logic [QW-1:0] qi;
  logic          ent_hit, end_scan;
  logic [2:0]    e_kind;
  logic [31:0]   e_seq;
  logic          e_not, e_last;
  logic [CW-1:0] cnt_after;

  // queue pointer wrap for any depth
  function automatic logic [QW-1:0] qwrap(input logic [QW:0] v);
    if (v >= (QW+1)'(ACK_QUEUE_DEPTH)) return QW'(v - (QW+1)'(ACK_QUEUE_DEPTH));
    return QW'(v);
  endfunction

  assign ti = idx[TW-1:0];
  assign qi = qwrap({1'b0, head} + (QW+1)'(idx));

  always_comb begin
    ent_hit = 1'b0;
    end_scan = 1'b0;
    e_kind = rdat_pkg::KIND_ASSIGNED;
    e_seq = r_seq;
    e_not = 1'b0;
    e_last = 1'b0;
    cnt_after = count;
    case (r_mode)
      rdat_pkg::MODE_SEND: begin
        if (idx == IW'(TABLE_DEPTH)) begin
          ent_hit = 1'b1; e_kind = rdat_pkg::KIND_FULL;
          e_seq = next_out_seq; e_not = r_wn; e_last = 1'b1;
        end else if (!pvalid[ti]) begin
          ent_hit = 1'b1; e_kind = rdat_pkg::KIND_ASSIGNED;
          e_seq = next_out_seq; e_not = r_wn; e_last = 1'b1;
        end
        end_scan = r_found;
      end
      rdat_pkg::MODE_DATA: begin
        ent_hit = !r_found;
        end_scan = r_found;
        e_last = 1'b1;
        if (r_seq == expected_in_seq && count < CW'(ACK_QUEUE_DEPTH)) begin
          e_kind = rdat_pkg::KIND_DATA_OK;
          cnt_after = count + CW'(1);
        end else begin
          e_kind = rdat_pkg::KIND_DATA_REJ;
        end
      end
      rdat_pkg::MODE_ACK: begin
        end_scan = r_found;
        e_last = 1'b1;
        if (idx == IW'(TABLE_DEPTH)) begin
          ent_hit = 1'b1; e_kind = rdat_pkg::KIND_UNMATCHED;
        end else if (pvalid[ti] && pseq[ti] == r_seq) begin
          ent_hit = 1'b1; e_kind = rdat_pkg::KIND_SUCCESS; e_not = pnot[ti];
        end
      end
      rdat_pkg::MODE_TICK: begin
        end_scan = (idx == IW'(TABLE_DEPTH)) || nres == 5'(rdat_pkg::MAX_RESULTS);
        if (!end_scan && pvalid[ti] && (current_time - ptime[ti]) >= timeout_ticks) begin
          ent_hit = 1'b1; e_kind = rdat_pkg::KIND_TIMEOUT;
          e_seq = pseq[ti]; e_not = pnot[ti];
        end
      end
      rdat_pkg::MODE_DRAIN: begin
        end_scan = idx[4:0] == take || idx >= IW'(count);
        if (!end_scan) begin
          ent_hit = 1'b1; e_kind = rdat_pkg::KIND_ACK_OUT; e_seq = aq[qi];
          e_last = idx[4:0] + 5'd1 == take;
          cnt_after = count - CW'(take);
        end
      end
      default: end_scan = 1'b1;
    endcase
  end

  assign sts.hit = ent_hit;
  assign sts.scan_done = end_scan;
  assign sts.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= rdat_pkg::TIMEOUT_RESET;
      next_out_seq <= '0;
      expected_in_seq <= '0;
      current_time <= '0;
      pvalid <= '0;
      head <= '0;
      count <= '0;
      out_valid <= 1'b0;
      r_found <= 1'b0;
      idx <= '0;
      nres <= '0;
    end else begin
      if (cfg_valid) timeout_ticks <= cfg_data;
      if (cmd.start) begin
        r_mode <= mode; r_seq <= seq_number; r_wn <= wants_notify;
        r_lil <= last_in_list; r_found <= 1'b0; idx <= '0; nres <= '0;
        take <= (int'(count) > rdat_pkg::MAX_RESULTS) ?
                5'(rdat_pkg::MAX_RESULTS) : 5'(count);
        if (mode == rdat_pkg::MODE_TICK) current_time <= current_time + 32'd1;
        if (mode == rdat_pkg::MODE_CLEAR) begin
          pvalid <= '0; count <= '0; head <= '0;
        end
      end
      if (cmd.scan_step) idx <= idx + IW'(1);
      if (cmd.emit) begin
        out_valid <= 1'b1;
        kind <= e_kind; seq_out <= e_seq; notify <= e_not;
        ack_total <= (e_kind == rdat_pkg::KIND_ACK_OUT) ? take : 5'd0;
        end_of_list <= (e_kind == rdat_pkg::KIND_SUCCESS ||
                        e_kind == rdat_pkg::KIND_UNMATCHED) ? r_lil : 1'b0;
        acks_waiting <= cnt_after != '0;
        last <= e_last;
        nres <= nres + 5'd1;
        if (r_mode != rdat_pkg::MODE_TICK && r_mode != rdat_pkg::MODE_DRAIN)
          r_found <= 1'b1;
        case (e_kind)
          rdat_pkg::KIND_ASSIGNED: begin
            pvalid[ti] <= 1'b1; pseq[ti] <= next_out_seq;
            ptime[ti] <= current_time; pnot[ti] <= r_wn;
            next_out_seq <= next_out_seq + 32'd1;
          end
          rdat_pkg::KIND_DATA_OK: begin
            aq[qwrap({1'b0, head} + (QW+1)'(count))] <= r_seq;
            count <= cnt_after;
            expected_in_seq <= expected_in_seq + 32'd1;
          end
          rdat_pkg::KIND_SUCCESS, rdat_pkg::KIND_TIMEOUT: pvalid[ti] <= 1'b0;
          rdat_pkg::KIND_ACK_OUT: if (e_last) begin
            count <= cnt_after; head <= qwrap({1'b0, head} + (QW+1)'(take));
          end
          default: ;
        endcase
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/reliable_delivery_ack_tracker.sv -----
// channel | valid    | ready    | payload
// in      | in_valid | in_ready | mode, seq_number, wants_notify, last_in_list
// out     | out_valid| out_ready| kind, seq_out, notify, acks_waiting, ack_total,
//         |          |          | end_of_list, last
// cfg     | cfg_valid| cfg_ready| cfg_data (timeout_ticks)
// An item is handled by a single-entry scan that steps over entries without a result
// and stops on each result word until it is emitted: send, data and ack give one word,
// a tick gives up to sixteen timeouts and a drain up to sixteen queued acks.
// Tick results are held back one word so last marks the final timeout word.
// rst is synchronous: table, queue, counters cleared, timeout back to 1000.
// A stalled output holds back result words; in_ready stays low until the scan ends.
module reliable_delivery_ack_tracker #(
  parameter int TABLE_DEPTH = rdat_pkg::TABLE_DEPTH_DEF,
  parameter int ACK_QUEUE_DEPTH = rdat_pkg::ACK_QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [31:0] seq_number,
  input  logic        wants_notify,
  input  logic        last_in_list,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [31:0] seq_out,
  output logic        notify,
  output logic        acks_waiting,
  output logic [4:0]  ack_total,
  output logic        end_of_list,
  output logic        last
);

  rdat_pkg::ctl_cmd_t cmd;
  rdat_pkg::ctl_sts_t sts;
  logic               dp_valid, dp_ready;
  logic [2:0]         dp_kind;
  logic [31:0]        dp_seq;
  logic               dp_not, dp_aw, dp_eol, dp_last;
  logic [4:0]         dp_tot;
  logic               hold_tick;

  assign cfg_ready = 1'b1;

  rdat_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  rdat_dpath #(.TABLE_DEPTH(TABLE_DEPTH), .ACK_QUEUE_DEPTH(ACK_QUEUE_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_valid(cfg_valid), .cfg_data(cfg_data),
    .mode(mode), .seq_number(seq_number), .wants_notify(wants_notify),
    .last_in_list(last_in_list),
    .out_valid(dp_valid), .out_ready(dp_ready),
    .kind(dp_kind), .seq_out(dp_seq), .notify(dp_not), .acks_waiting(dp_aw),
    .ack_total(dp_tot), .end_of_list(dp_eol), .last(dp_last)
  );

  // one-word holding stage: a timeout word waits until the next one or the scan end
  assign hold_tick = dp_valid && dp_kind == rdat_pkg::KIND_TIMEOUT && !dp_last
                     && !sts.scan_done && !sts.hit;
  assign dp_ready = !out_valid && !hold_tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (dp_valid && dp_ready) begin
        out_valid <= 1'b1;
        kind <= dp_kind; seq_out <= dp_seq; notify <= dp_not;
        acks_waiting <= dp_aw; ack_total <= dp_tot; end_of_list <= dp_eol;
        last <= dp_last || (dp_kind == rdat_pkg::KIND_TIMEOUT && cmd.finish);
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_last_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == rdat_pkg::KIND_ASSIGNED || kind == rdat_pkg::KIND_FULL ||
    kind == rdat_pkg::KIND_DATA_OK || kind == rdat_pkg::KIND_DATA_REJ) |-> last)
    else $error("single-result kind without last");
  a_eol: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_list |-> (kind == rdat_pkg::KIND_SUCCESS ||
    kind == rdat_pkg::KIND_UNMATCHED))
    else $error("end_of_list on wrong kind");
  a_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != rdat_pkg::KIND_ACK_OUT |-> ack_total == 5'd0)
    else $error("ack_total outside drain");

endmodule
